/* hw/rtl/ray_triangle_uv_interpolate_core_defines.svh */
// Assertion macros shared by the ray/triangle texture interpolation RTL.
`ifndef RAY_TRIANGLE_UV_INTERPOLATE_CORE_DEFINES_SVH
`define RAY_TRIANGLE_UV_INTERPOLATE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RTUI_ASSERT_SAME(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RTUI_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* hw/rtl/rtui_pkg.sv */
// Package: field widths, status codes and shared types of the ray/triangle UV core.
package rtui_pkg;

    localparam int XYZ_WIDTH      = 63;
    localparam int TEX_WIDTH      = 31;
    localparam int TEX_PAIR_WIDTH = 2 * TEX_WIDTH;
    localparam int THR_WIDTH      = 20;
    localparam int STATUS_WIDTH   = 3;
    localparam logic [THR_WIDTH-1:0] THR_RESET = THR_WIDTH'(11);

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_HIT      = 3'd0,
        ST_PARALLEL = 3'd1,
        ST_U_RANGE  = 3'd2,
        ST_V_RANGE  = 3'd3,
        ST_NO_TEX   = 3'd4
    } t_status;

    // Texture side data carried along the geometry stages.
    typedef struct packed {
        logic [2:0]                     present;
        logic [2:0][TEX_PAIR_WIDTH-1:0] tex;
    } t_tex_set;

endpackage

/* hw/rtl/ray_triangle_uv_interpolate_core.sv */
// Ray/triangle intersection test with barycentric texture coordinate interpolation.
//
// Input channel: i_valid / o_stall, one ray plus triangle per beat, fields on their own
// ports. A beat is taken at a clock edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall, one result per input beat (hit, status, tex_u,
// tex_v), in input order. A result is taken at an edge with o_valid high, i_stall low.
// Config channel: i_cfg_valid / o_cfg_ready writes the 20-bit determinant threshold;
// ready is always high. Write it only while no beat is in flight.
// Throughput: one beat per cycle while no output stall holds the pipeline. Twelve stages
// form the determinant, the two numerators, the hit checks, the weighted texture sums and
// the divider set-up (multiplier operands split to <=32 bits); then a restoring divider
// retires one quotient bit per stage for u and v, and an output register follows.
// Reset: synchronous, active low; clears all valid bits and loads threshold 11.
// Stall: while the output holds a result and i_stall is high, the whole pipeline
// freezes and o_stall is raised; nothing is dropped or repeated.
`include "ray_triangle_uv_interpolate_core_defines.svh"

module ray_triangle_uv_interpolate_core #(
    parameter int COORD_WIDTH = 21
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [rtui_pkg::THR_WIDTH-1:0]       i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [rtui_pkg::XYZ_WIDTH-1:0]       i_ray_origin,
    input  logic [rtui_pkg::XYZ_WIDTH-1:0]       i_ray_direction,
    input  logic [rtui_pkg::XYZ_WIDTH-1:0]       i_corner_a,
    input  logic [rtui_pkg::XYZ_WIDTH-1:0]       i_corner_b,
    input  logic [rtui_pkg::XYZ_WIDTH-1:0]       i_corner_c,
    input  logic [rtui_pkg::TEX_PAIR_WIDTH-1:0]  i_tex_a,
    input  logic [rtui_pkg::TEX_PAIR_WIDTH-1:0]  i_tex_b,
    input  logic [rtui_pkg::TEX_PAIR_WIDTH-1:0]  i_tex_c,
    input  logic [2:0]                           i_tex_present,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic                                 o_hit,
    output logic [rtui_pkg::STATUS_WIDTH-1:0]    o_status,
    output logic signed [rtui_pkg::TEX_WIDTH-1:0] o_tex_u,
    output logic signed [rtui_pkg::TEX_WIDTH-1:0] o_tex_v
);
    import rtui_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int DW   = CW + 1;          // coordinate differences
    localparam int PW   = 2 * DW + 1;      // cross product components
    localparam int K1   = (PW + 1) / 2;    // low split of a cross component
    localparam int HW   = PW - K1;
    localparam int CPW  = DW + PW;         // one dot product term
    localparam int DTW  = CPW + 2;         // dot product sum
    localparam int SW   = DTW + 1;         // after sign fix
    localparam int WU   = SW - 1;          // unsigned weight / determinant
    localparam int K    = (WU + 2) / 3;    // weight chunk
    localparam int WK   = 3 * K;
    localparam int TW   = TEX_WIDTH;
    localparam int MW   = TW + K + 1;      // texture x chunk product
    localparam int NW   = TW + 3 * K + 4;  // interpolation numerator
    localparam int RW   = NW + 2;          // divider remainder
    localparam int QB   = TW;              // quotient bits
    localparam int DVW  = WU + 1;          // doubled determinant
    localparam int LAST = 12 + QB;         // index of the output stage valid

    logic                 en;
    logic [LAST:0]        r_vld;
    logic [THR_WIDTH-1:0] r_det_threshold;

    assign en          = !(r_vld[LAST] && i_stall);
    assign o_stall     = !en;
    assign o_valid     = r_vld[LAST];
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_det_threshold <= THR_RESET;
        end else if (i_cfg_valid) begin
            r_det_threshold <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAST-1:0], i_valid};
        end
    end

    // ---------------- stage 1: unpack, edges ----------------
    logic signed [CW-1:0] w_o [3], w_d [3], w_a [3], w_b [3], w_c [3];
    logic signed [DW-1:0] r1_e1 [3], r1_e2 [3], r1_t [3], r1_d [3];
    t_tex_set             r1_tx;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_o[k] = $signed(i_ray_origin[k*CW +: CW]);
            w_d[k] = $signed(i_ray_direction[k*CW +: CW]);
            w_a[k] = $signed(i_corner_a[k*CW +: CW]);
            w_b[k] = $signed(i_corner_b[k*CW +: CW]);
            w_c[k] = $signed(i_corner_c[k*CW +: CW]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r1_e1[k] <= w_b[k] - w_a[k];
                r1_e2[k] <= w_c[k] - w_a[k];
                r1_t[k]  <= w_o[k] - w_a[k];
                r1_d[k]  <= DW'(w_d[k]);
            end
            r1_tx.present <= i_tex_present;
            r1_tx.tex[0]  <= i_tex_a;
            r1_tx.tex[1]  <= i_tex_b;
            r1_tx.tex[2]  <= i_tex_c;
        end
    end

    // ---------------- stage 2: cross product terms ----------------
    // p = d x e2, q = t x e1; term 2k is a[i]*b[j], term 2k+1 is a[j]*b[i]
    logic signed [2*DW-1:0] r2_pm [6], r2_qm [6];
    logic signed [DW-1:0]   r2_e1 [3], r2_t [3], r2_d [3];
    t_tex_set               r2_tx;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r2_pm[2*k]   <= r1_d[(k+1)%3] * r1_e2[(k+2)%3];
                r2_pm[2*k+1] <= r1_d[(k+2)%3] * r1_e2[(k+1)%3];
                r2_qm[2*k]   <= r1_t[(k+1)%3] * r1_e1[(k+2)%3];
                r2_qm[2*k+1] <= r1_t[(k+2)%3] * r1_e1[(k+1)%3];
            end
            r2_e1 <= r1_e1;
            r2_t  <= r1_t;
            r2_d  <= r1_d;
            r2_tx <= r1_tx;
        end
    end

    // ---------------- stage 3: cross products ----------------
    logic signed [PW-1:0] r3_p [3], r3_q [3];
    logic signed [DW-1:0] r3_e1 [3], r3_t [3], r3_d [3];
    t_tex_set             r3_tx;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r3_p[k] <= r2_pm[2*k] - r2_pm[2*k+1];
                r3_q[k] <= r2_qm[2*k] - r2_qm[2*k+1];
            end
            r3_e1 <= r2_e1;
            r3_t  <= r2_t;
            r3_d  <= r2_d;
            r3_tx <= r2_tx;
        end
    end

    // ---------------- stage 4: dot product partial products ----------------
    // dot 0: det = e1.p, dot 1: U = t.p, dot 2: V = d.q
    logic signed [DW-1:0]    w4_a [3][3];
    logic signed [PW-1:0]    w4_b [3][3];
    logic signed [DW+K1:0]   r4_lo [3][3];
    logic signed [DW+HW-1:0] r4_hi [3][3];
    t_tex_set                r4_tx;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w4_a[0][k] = r3_e1[k];
            w4_b[0][k] = r3_p[k];
            w4_a[1][k] = r3_t[k];
            w4_b[1][k] = r3_p[k];
            w4_a[2][k] = r3_d[k];
            w4_b[2][k] = r3_q[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    r4_lo[i][k] <= w4_a[i][k] * $signed({1'b0, w4_b[i][k][K1-1:0]});
                    r4_hi[i][k] <= w4_a[i][k] * $signed(w4_b[i][k][PW-1:K1]);
                end
            end
            r4_tx <= r3_tx;
        end
    end

    // ---------------- stage 5: dot product terms ----------------
    logic signed [CPW-1:0] w5_hi [3][3], w5_lo [3][3];
    logic signed [CPW-1:0] r5_term [3][3];
    t_tex_set              r5_tx;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                w5_hi[i][k] = r4_hi[i][k];
                w5_lo[i][k] = r4_lo[i][k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    r5_term[i][k] <= (w5_hi[i][k] <<< K1) + w5_lo[i][k];
                end
            end
            r5_tx <= r4_tx;
        end
    end

    // ---------------- stage 6: dot product sums ----------------
    logic signed [DTW-1:0] r6_dot [3];
    t_tex_set              r6_tx;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r6_dot[i] <= r5_term[i][0] + r5_term[i][1] + r5_term[i][2];
            end
            r6_tx <= r5_tx;
        end
    end

    // ---------------- stage 7: make det non-negative ----------------
    logic signed [SW-1:0] w7_x [3];
    logic signed [SW-1:0] r7_dot [3];
    t_tex_set             r7_tx;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w7_x[i] = r6_dot[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r7_dot[i] <= r6_dot[0][DTW-1] ? -w7_x[i] : w7_x[i];
            end
            r7_tx <= r6_tx;
        end
    end

    // ---------------- stage 8: hit checks, weights ----------------
    logic signed [SW-1:0] w8_det, w8_un, w8_vn, w8_wn, w8_thr;
    logic signed [SW:0]   w8_uv;
    t_status              w8_st;
    t_status              r8_st;
    logic [WK-1:0]        r8_w [3];
    logic [WU-1:0]        r8_det;
    t_tex_set             r8_tx;

    always_comb begin
        w8_det = r7_dot[0];
        w8_un  = r7_dot[1];
        w8_vn  = r7_dot[2];
        w8_thr = SW'(r_det_threshold);
        w8_uv  = w8_un + w8_vn;
        w8_wn  = w8_det - w8_un - w8_vn;
        if (w8_det == '0 || w8_det < w8_thr) begin
            w8_st = ST_PARALLEL;
        end else if (w8_un < 0 || w8_det < w8_un) begin
            w8_st = ST_U_RANGE;
        end else if (w8_vn < 0 || w8_det < w8_uv) begin
            w8_st = ST_V_RANGE;
        end else if (r7_tx.present != 3'b111) begin
            w8_st = ST_NO_TEX;
        end else begin
            w8_st = ST_HIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_st   <= w8_st;
            r8_w[0] <= WK'(w8_wn[WU-1:0]);
            r8_w[1] <= WK'(w8_un[WU-1:0]);
            r8_w[2] <= WK'(w8_vn[WU-1:0]);
            r8_det  <= w8_det[WU-1:0];
            r8_tx   <= r7_tx;
        end
    end

    // ---------------- stage 9: texture x weight chunk products ----------------
    // index [coord][weight][chunk]; coord 0 is u, 1 is v
    logic signed [MW-1:0] r9_m [2][3][3];
    t_status              r9_st;
    logic [WU-1:0]        r9_det;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 2; c++) begin
                for (int w = 0; w < 3; w++) begin
                    for (int j = 0; j < 3; j++) begin
                        r9_m[c][w][j] <= $signed(r8_tx.tex[w][c*TW +: TW])
                                       * $signed({1'b0, r8_w[w][j*K +: K]});
                    end
                end
            end
            r9_st  <= r8_st;
            r9_det <= r8_det;
        end
    end

    // ---------------- stage 10: per-weight sums ----------------
    logic signed [NW-1:0] w10_m [2][3][3];
    logic signed [NW-1:0] r10_s [2][3];
    t_status              r10_st;
    logic [WU-1:0]        r10_det;

    always_comb begin
        for (int c = 0; c < 2; c++) begin
            for (int w = 0; w < 3; w++) begin
                for (int j = 0; j < 3; j++) begin
                    w10_m[c][w][j] = r9_m[c][w][j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 2; c++) begin
                for (int w = 0; w < 3; w++) begin
                    r10_s[c][w] <= w10_m[c][w][0] + (w10_m[c][w][1] <<< K)
                                 + (w10_m[c][w][2] <<< (2 * K));
                end
            end
            r10_st  <= r9_st;
            r10_det <= r9_det;
        end
    end

    // ---------------- stage 11: numerators ----------------
    logic signed [NW-1:0] r11_n [2];
    t_status              r11_st;
    logic [WU-1:0]        r11_det;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 2; c++) begin
                r11_n[c] <= r10_s[c][0] + r10_s[c][1] + r10_s[c][2];
            end
            r11_st  <= r10_st;
            r11_det <= r10_det;
        end
    end

    // ---------------- stage 12: divider set-up ----------------
    // round to nearest, ties away: q = (2|n| + det) / (2 det)
    logic [NW-1:0] w12_mag [2];
    logic [RW-1:0] r_dv_rem [QB+1][2];
    logic [QB-1:0] r_dv_q   [QB+1][2];
    logic [1:0]    r_dv_neg [QB+1];
    logic [DVW-1:0] r_dv_den [QB+1];
    t_status       r_dv_st  [QB+1];

    always_comb begin
        for (int c = 0; c < 2; c++) begin
            w12_mag[c] = r11_n[c][NW-1] ? NW'(-r11_n[c]) : NW'(r11_n[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 2; c++) begin
                r_dv_rem[0][c] <= (RW'(w12_mag[c]) << 1) + RW'(r11_det);
                r_dv_q[0][c]   <= '0;
                r_dv_neg[0][c] <= r11_n[c][NW-1];
            end
            r_dv_den[0] <= DVW'(r11_det) << 1;
            r_dv_st[0]  <= r11_st;
        end
    end

    // ---------------- divider: one quotient bit per stage ----------------
    for (genvar s = 0; s < QB; s++) begin : g_div
        localparam int B = QB - 1 - s;
        logic [RW-1:0] w_sh;
        logic          w_ge [2];

        assign w_sh = RW'(r_dv_den[s]) << B;

        always_comb begin
            for (int c = 0; c < 2; c++) begin
                w_ge[c] = r_dv_rem[s][c] >= w_sh;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int c = 0; c < 2; c++) begin
                    r_dv_rem[s+1][c] <= w_ge[c] ? r_dv_rem[s][c] - w_sh : r_dv_rem[s][c];
                    r_dv_q[s+1][c]   <= {r_dv_q[s][c][QB-2:0], w_ge[c]};
                end
                r_dv_neg[s+1] <= r_dv_neg[s];
                r_dv_den[s+1] <= r_dv_den[s];
                r_dv_st[s+1]  <= r_dv_st[s];
            end
        end
    end

    // ---------------- output register ----------------
    t_status              r_o_st;
    logic signed [TW-1:0] r_o_u, r_o_v;
    logic                 w_hit;

    assign w_hit = (r_dv_st[QB] == ST_HIT);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_st <= r_dv_st[QB];
            if (w_hit) begin
                r_o_u <= r_dv_neg[QB][0] ? -$signed(r_dv_q[QB][0]) : $signed(r_dv_q[QB][0]);
                r_o_v <= r_dv_neg[QB][1] ? -$signed(r_dv_q[QB][1]) : $signed(r_dv_q[QB][1]);
            end else begin
                r_o_u <= '0;
                r_o_v <= '0;
            end
        end
    end

    assign o_status = r_o_st;
    assign o_hit    = (r_o_st == ST_HIT);
    assign o_tex_u  = r_o_u;
    assign o_tex_v  = r_o_v;

    // ---------------- assertions ----------------
    `RTUI_ASSERT_SAME(a_hit_matches_status, i_clk, i_rst_n, o_valid, o_hit == (o_status == ST_HIT), "hit flag disagrees with status")
    `RTUI_ASSERT_SAME(a_miss_is_zero, i_clk, i_rst_n, o_valid && !o_hit, o_tex_u == '0 && o_tex_v == '0, "miss carries nonzero texture coordinates")
    `RTUI_ASSERT_SAME(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall, "input stalled without a blocked result")
    `RTUI_ASSERT_NEXT(a_beat_enters, i_clk, i_rst_n, i_valid && !o_stall, r_vld[0], "accepted beat lost at pipeline entry")

endmodule
